// ----- hdl/brc_pkg.sv -----
// ----------------------------------------------------------------------------
// brc_pkg
// Types and codes shared by the binary relation closure engine and its checker.
// ----------------------------------------------------------------------------
`default_nettype none
package brc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } brc_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] CFG_REFLEXIVE = 2'd0;
  localparam logic [1:0] CFG_ROUNDS    = 2'd1;

  localparam int ATOM_W = 11;
  localparam int PAIR_W = 2 * ATOM_W;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ATOM_W-1:0] src_atom;
    logic [ATOM_W-1:0] dst_atom;
    logic [9:0]        read_index;
  } brc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ATOM_W-1:0] pair_src;
    logic [ATOM_W-1:0] pair_dst;
    logic [10:0]       pair_count;
    logic [10:0]       rounds_used;
  } brc_out_t;

endpackage
`default_nettype wire

// ----- hdl/binary_relation_closure.sv -----
// ----------------------------------------------------------------------------
// binary_relation_closure
// Pair store with in-place transitive closure and optional identity pairs.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | brc_in_t
// out_    | output    | out_valid/out_stall | brc_out_t
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load and clear answer from the idle state; a read passes S_RD_WAIT and S_FINISH.
// A close walks the store through the single read port: each round compares every
// pair with every other and scans the store for each candidate, and the identity
// pass scans the earlier edges for each atom. The block takes no new transaction
// during a close. Reset is synchronous; the store needs no clearing pass. A stalled
// result holds the block until it has been taken.
`default_nettype none
module binary_relation_closure #(
  parameter int PAIR_CAPACITY = 1024,
  parameter int ATOM_IDS      = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire brc_pkg::brc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output brc_pkg::brc_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [10:0]       cfg_data
);
  import brc_pkg::*;

  localparam int AW = $clog2(PAIR_CAPACITY);
  localparam int CW = $clog2(PAIR_CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_R_CHECK, S_I_RD, S_I_GET, S_J_RD, S_J_GET,
    S_M_RD, S_M_GET, S_APPEND, S_X_RD, S_X_GET, S_X_TEST, S_XS_RD,
    S_XS_GET, S_FINISH
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r, load_r, n_r, i_r, j_r, k_r;
  logic [10:0]       rounds_r, last_r, limit_r;
  logic              refl_r, grew_r, phase_r;
  logic [ATOM_W-1:0] a_r, b_r;
  logic [PAIR_W-1:0] cand_r;
  logic [1:0]        status_r;
  logic [ATOM_W-1:0] rsrc_r, rdst_r;
  logic              out_valid_r;
  brc_out_t          out_r;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [PAIR_W-1:0] wdata, rdata;
  logic [ATOM_W-1:0] x_atom;
  logic              slot_free, accept, full;

  brc_pair_ram #(.DEPTH(PAIR_CAPACITY), .WIDTH(PAIR_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign full      = 32'(cnt_r) >= PAIR_CAPACITY;
  assign x_atom    = phase_r ? b_r : a_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = {in_data.src_atom, in_data.dst_atom};
    raddr = '0;
    case (state_r)
      S_IDLE: begin
        we    = accept && (in_data.operation == OP_LOAD) && !full;
        raddr = AW'(in_data.read_index);
      end
      S_I_RD:   raddr = i_r[AW-1:0];
      S_J_RD:   raddr = j_r[AW-1:0];
      S_M_RD:   raddr = k_r[AW-1:0];
      S_X_RD:   raddr = i_r[AW-1:0];
      S_XS_RD:  raddr = k_r[AW-1:0];
      S_APPEND: begin
        we    = !full;
        wdata = cand_r;
      end
      default: raddr = '0;
    endcase
    if (state_r == S_XS_RD && k_r >= i_r) begin
      we    = !full;
      wdata = {x_atom, x_atom};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      load_r      <= '0;
      last_r      <= '0;
      limit_r     <= 11'd100;
      refl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REFLEXIVE) begin
          refl_r <= cfg_data[0];
        end else if (cfg_index == CFG_ROUNDS) begin
          limit_r <= cfg_data;
        end
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_r.status      <= ST_OK;
            out_r.pair_src    <= '0;
            out_r.pair_dst    <= '0;
            out_r.rounds_used <= last_r;
            out_r.pair_count  <= 11'(cnt_r);
            rsrc_r            <= '0;
            rdst_r            <= '0;
            status_r          <= ST_OK;
            case (in_data.operation)
              OP_LOAD: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_r.status <= ST_FULL;
                end else begin
                  cnt_r            <= cnt_r + 1'b1;
                  load_r           <= load_r + 1'b1;
                  out_r.pair_count <= 11'(cnt_r + 1'b1);
                end
              end
              OP_CLOSE: begin
                rounds_r <= '0;
                grew_r   <= 1'b1;
                state_r  <= S_R_CHECK;
              end
              OP_READ: begin
                if (32'(in_data.read_index) < 32'(cnt_r)) begin
                  state_r <= S_RD_WAIT;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_r.status <= ST_BAD;
                end
              end
              default: begin
                cnt_r            <= '0;
                load_r           <= '0;
                out_r.pair_count <= '0;
                out_valid_r      <= 1'b1;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          rsrc_r  <= rdata[PAIR_W-1:ATOM_W];
          rdst_r  <= rdata[ATOM_W-1:0];
          state_r <= S_FINISH;
        end
        S_R_CHECK: begin
          if (grew_r && rounds_r < limit_r) begin
            grew_r   <= 1'b0;
            rounds_r <= rounds_r + 1'b1;
            n_r      <= cnt_r;
            i_r      <= '0;
            state_r  <= S_I_RD;
          end else begin
            last_r <= rounds_r;
            i_r    <= '0;
            state_r <= refl_r ? S_X_RD : S_FINISH;
          end
        end
        S_I_RD: begin
          state_r <= (i_r >= n_r) ? S_R_CHECK : S_I_GET;
        end
        S_I_GET: begin
          a_r     <= rdata[PAIR_W-1:ATOM_W];
          b_r     <= rdata[ATOM_W-1:0];
          j_r     <= '0;
          state_r <= S_J_RD;
        end
        S_J_RD: begin
          if (j_r >= n_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_I_RD;
          end else begin
            state_r <= S_J_GET;
          end
        end
        S_J_GET: begin
          if (rdata[PAIR_W-1:ATOM_W] == b_r) begin
            cand_r  <= {a_r, rdata[ATOM_W-1:0]};
            k_r     <= '0;
            state_r <= S_M_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_J_RD;
          end
        end
        S_M_RD: begin
          state_r <= (k_r >= cnt_r) ? S_APPEND : S_M_GET;
        end
        S_M_GET: begin
          if (rdata == cand_r) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_J_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_M_RD;
          end
        end
        S_APPEND: begin
          if (full) begin
            last_r   <= rounds_r;
            status_r <= ST_FULL;
            state_r  <= S_FINISH;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            grew_r  <= 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_J_RD;
          end
        end
        S_X_RD: begin
          state_r <= (i_r >= load_r) ? S_FINISH : S_X_GET;
        end
        S_X_GET: begin
          a_r     <= rdata[PAIR_W-1:ATOM_W];
          b_r     <= rdata[ATOM_W-1:0];
          phase_r <= 1'b0;
          state_r <= S_X_TEST;
        end
        S_X_TEST: begin
          // The second atom of an edge counts as seen when it equals the first.
          if (32'(x_atom) >= ATOM_IDS || (phase_r && b_r == a_r)) begin
            if (phase_r) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_X_RD;
            end else begin
              phase_r <= 1'b1;
            end
          end else begin
            k_r     <= '0;
            state_r <= S_XS_RD;
          end
        end
        S_XS_RD: begin
          if (k_r >= i_r) begin
            if (full) begin
              status_r <= ST_FULL;
              state_r  <= S_FINISH;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              if (phase_r) begin
                i_r     <= i_r + 1'b1;
                state_r <= S_X_RD;
              end else begin
                phase_r <= 1'b1;
                state_r <= S_X_TEST;
              end
            end
          end else begin
            state_r <= S_XS_GET;
          end
        end
        S_XS_GET: begin
          // An atom met in an earlier loaded edge already has its identity pair.
          if (rdata[PAIR_W-1:ATOM_W] == x_atom || rdata[ATOM_W-1:0] == x_atom) begin
            if (phase_r) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_X_RD;
            end else begin
              phase_r <= 1'b1;
              state_r <= S_X_TEST;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_XS_RD;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_valid_r       <= 1'b1;
            out_r.status      <= status_r;
            out_r.pair_src    <= rsrc_r;
            out_r.pair_dst    <= rdst_r;
            out_r.pair_count  <= 11'(cnt_r);
            out_r.rounds_used <= last_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brc_pair_ram.sv -----
// ----------------------------------------------------------------------------
// brc_pair_ram
// Single write, single read pair store with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module brc_pair_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 22
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/brc_checker.sv -----
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks on the closure engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module brc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire brc_pkg::brc_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire brc_pkg::brc_out_t out_data
);
  import brc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BAD |->
      out_data.pair_src == '0 && out_data.pair_dst == '0)
    else $error("failed read returned a pair");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_CLEAR |=>
      out_valid && out_data.pair_count == '0)
    else $error("clear did not empty the store");

endmodule

bind binary_relation_closure brc_checker u_brc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
